/* design/gmvm_pkg.sv */
// Package with the grid sizes, move tables and move-mask rules of the grid move validity mask.
`timescale 1ns / 1ps

package gmvm_pkg;

	localparam int MAX_ROWS   = 64;
	localparam int MAX_COLS   = 64;
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int ADDR_W     = ROW_W + COL_W;
	localparam int MAP_DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int DIM_W      = 7;
	localparam int K_W        = 3;
	localparam int MOVE_W     = 5;
	localparam int MASK_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [K_W-1:0] K_MIN = 3'd2;
	localparam logic [K_W-1:0] K_8   = 3'd3;
	localparam logic [K_W-1:0] K_16  = 3'd4;
	localparam logic [K_W-1:0] K_MAX = 3'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEIGHT = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_K      = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [2:0] dr;
		logic signed [2:0] dc;
	} move_delta_t;

	localparam int FOUR_DR [4] = '{0, 1, -1, 0};
	localparam int FOUR_DC [4] = '{1, 0, 0, -1};

	localparam int MV_DR [32] = '{
		0, 1, 1, 1, 0, -1, -1, -1,
		1, 2, 2, 1, -1, -2, -2, -1,
		1, 2, 3, 3, 3, 3, 2, 1, -1, -2, -3, -3, -3, -3, -2, -1};
	localparam int MV_DC [32] = '{
		1, 1, 0, -1, -1, -1, 0, 1,
		2, 1, -1, -2, -2, -1, 1, 2,
		3, 3, 2, 1, -1, -2, -3, -3, -3, -3, -2, -1, 1, 2, 3, 3};

	function automatic move_delta_t gmvm_delta(input logic [K_W-1:0] k,
		input logic [MOVE_W-1:0] m);
		move_delta_t d;
		if (k == K_MIN) begin
			d.dr = 3'(FOUR_DR[m[1:0]]);
			d.dc = 3'(FOUR_DC[m[1:0]]);
		end else begin
			d.dr = 3'(MV_DR[m]);
			d.dc = 3'(MV_DC[m]);
		end
		return d;
	endfunction

	function automatic logic [MOVE_W-1:0] gmvm_last_move(input logic [K_W-1:0] k);
		logic [MOVE_W-1:0] last;
		case (k)
			K_MIN:   last = 5'd3;
			K_8:     last = 5'd7;
			K_16:    last = 5'd15;
			default: last = 5'd31;
		endcase
		return last;
	endfunction

	// Turns the per-move free flags into the legal-move mask, applying the
	// corner-cutting rules of each neighborhood size.
	function automatic logic [MASK_W-1:0] gmvm_mask(input logic [MASK_W-1:0] free,
		input logic [K_W-1:0] k);
		logic [MASK_W-1:0] mask;
		int m;
		if (k == K_MIN) begin
			mask = {28'd0, free[3:0]};
		end else begin
			mask = (k == K_8) ? 32'h0000_00FF : (k == K_16) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
			for (m = 0; m < 8; m += 2) begin
				if (!free[m]) begin
					mask[m] = 1'b0;
					mask[m + 1] = 1'b0;
					mask[(m == 0) ? 7 : m - 1] = 1'b0;
					if (k >= K_16) begin
						mask[m + 8] = 1'b0;
						mask[(m == 0) ? 15 : m + 7] = 1'b0;
					end
					if (k == K_MAX) begin
						mask[2 * m + 16] = 1'b0;
						mask[2 * m + 17] = 1'b0;
						mask[(m == 0) ? 30 : 2 * m + 14] = 1'b0;
						mask[(m == 0) ? 31 : 2 * m + 15] = 1'b0;
					end
				end
			end
			for (m = 1; m < 8; m += 2) begin
				if (!free[m]) begin
					mask[m] = 1'b0;
					if (k >= K_16) begin
						mask[m + 7] = 1'b0;
						mask[m + 8] = 1'b0;
					end
					if (k == K_MAX) begin
						mask[2 * m + 14] = 1'b0;
						mask[2 * m + 15] = 1'b0;
						mask[2 * m + 16] = 1'b0;
						mask[2 * m + 17] = 1'b0;
					end
				end
			end
			if (k >= K_16) begin
				for (m = 8; m < 16; m++) begin
					if (!free[m]) begin
						mask[m] = 1'b0;
						if (k == K_MAX) begin
							mask[2 * m] = 1'b0;
							mask[2 * m + 1] = 1'b0;
						end
					end
				end
			end
			if (k == K_MAX) begin
				for (m = 16; m < 32; m++) begin
					if (!free[m]) begin
						mask[m] = 1'b0;
					end
				end
			end
		end
		return mask;
	endfunction

endpackage

/* design/gmvm_ram.sv */
// Generic single-port RAM with a registered read port.
`timescale 1ns / 1ps

module gmvm_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* design/grid_move_validity_mask.sv */
// Top level of the grid move validity mask: obstacle map, neighbor scan and result register.
`timescale 1ns / 1ps
//
// The block holds a one-bit obstacle map of up to 64 by 64 cells in a single-port RAM.
// Input words carry op, row, col and blocked. A write word stores the cell's obstacle
// bit and produces no result; the next word is taken in the following cycle.
// A query word inside the grid reads its 2^k neighbor cells one per cycle through the RAM
// port, so it holds the input stalled from acceptance until its result is written to the
// output register; that single port sets the rate. A query outside the grid in use skips
// the scan and goes straight to the finish state, which writes a zero mask.
// The move_mask word is held in an output register with out_valid. While the receiver
// stalls, the word stays put and the block still accepts the next input word; a finished
// query then waits for the register to free before it is written.
// The configuration channel is always ready; register values saturate into range (k from the
// low three bits of cfg_data) and must only change while the block is idle. Reset clears the
// control state and sets the grid to 64 by 64 with k = 2. The map is not cleared: cells must
// be written before they are queried.
//

module grid_move_validity_mask (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              op,
	input  logic [gmvm_pkg::ROW_W-1:0]        row,
	input  logic [gmvm_pkg::COL_W-1:0]        col,
	input  logic                              blocked,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [gmvm_pkg::MASK_W-1:0]       move_mask,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gmvm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gmvm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import gmvm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t             state_q;
	logic [DIM_W-1:0]   height_q;
	logic [DIM_W-1:0]   width_q;
	logic [K_W-1:0]     k_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic               oob_q;
	logic [MOVE_W-1:0]  m_q;
	logic               out_valid_q;
	logic [MASK_W-1:0]  move_mask_q;
	logic               rd_s1;
	logic [MOVE_W-1:0]  mv_s1;
	logic               ongrid_s1;
	logic [MASK_W-1:0]  free_q;

	logic               in_acc;
	logic               q_oob;
	move_delta_t        delta;
	logic signed [7:0]  tr;
	logic signed [7:0]  tc;
	logic               on_grid;
	logic [ADDR_W-1:0]  ram_addr;
	logic               ram_we;
	logic [0:0]         ram_rdata;
	logic [DIM_W-1:0]   height_new;
	logic [DIM_W-1:0]   width_new;
	logic [K_W-1:0]     k_new;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign move_mask = move_mask_q;

	always_comb begin
		if (cfg_data == '0) begin
			height_new = 7'd1;
			width_new  = 7'd1;
		end else begin
			height_new = (cfg_data > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : cfg_data;
			width_new  = (cfg_data > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cfg_data;
		end
		if (cfg_data[K_W-1:0] < K_MIN) begin
			k_new = K_MIN;
		end else if (cfg_data[K_W-1:0] > K_MAX) begin
			k_new = K_MAX;
		end else begin
			k_new = cfg_data[K_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= 7'(MAX_ROWS);
			width_q  <= 7'(MAX_COLS);
			k_q      <= K_MIN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HEIGHT: height_q <= height_new;
				REG_WIDTH:  width_q  <= width_new;
				REG_K:      k_q      <= k_new;
				default:    ;
			endcase
		end
	end

	always_comb begin
		q_oob   = ({1'b0, row} >= height_q) || ({1'b0, col} >= width_q);
		delta   = gmvm_delta(k_q, m_q);
		tr      = $signed({2'b00, row_q}) + $signed({{5{delta.dr[2]}}, delta.dr});
		tc      = $signed({2'b00, col_q}) + $signed({{5{delta.dc[2]}}, delta.dc});
		on_grid = !tr[7] && !tc[7] && (tr[6:0] < height_q) && (tc[6:0] < width_q);
		ram_we  = in_acc && (op == OP_WRITE);
		if (state_q == ST_SCAN) begin
			ram_addr = {tr[ROW_W-1:0], tc[COL_W-1:0]};
		end else begin
			ram_addr = {row, col};
		end
	end

	gmvm_ram #(
		.WIDTH (1),
		.DEPTH (MAP_DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (blocked),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		mv_s1     <= m_q;
		ongrid_s1 <= on_grid;
		if (rd_s1) begin
			free_q[mv_s1] <= ongrid_s1 & ~ram_rdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			oob_q       <= 1'b0;
			m_q         <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
			move_mask_q <= '0;
		end else begin
			rd_s1 <= (state_q == ST_SCAN);
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (op == OP_QUERY)) begin
						row_q   <= row;
						col_q   <= col;
						oob_q   <= q_oob;
						m_q     <= '0;
						state_q <= q_oob ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					m_q <= m_q + 5'd1;
					if (m_q == gmvm_last_move(k_q)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						move_mask_q <= oob_q ? '0 : gmvm_mask(free_q, k_q);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* design/gmvm_checker.sv */
// Port-level assertion checker for the grid move validity mask, bound to the top level.
`timescale 1ns / 1ps

module gmvm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              op,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [gmvm_pkg::MASK_W-1:0]       move_mask
);

	import gmvm_pkg::*;

	// A result word that is stalled stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("move_mask word dropped while stalled");

	// A stalled result word keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(move_mask))
		else $error("move_mask changed while stalled");

	// An accepted query moves the block out of idle, so the input stalls next cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op == OP_QUERY) |=> in_stall)
		else $error("input not stalled after a query word");

	// A map write completes in its own cycle and leaves the input open.
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op == OP_WRITE) |=> !in_stall)
		else $error("input stalled after a write word");

endmodule

bind grid_move_validity_mask gmvm_checker u_gmvm_checker (.*);
